// File: design/edge_stream_relaxation_unit_defines.svh
// Assertion macros for the edge stream relaxation unit.
// Used by the top level; no other dependencies.
`ifndef EDGE_STREAM_RELAXATION_UNIT_DEFINES_SVH
`define EDGE_STREAM_RELAXATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during rst
`define ESR_ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("esr assertion failed");
// next-cycle implication, clocked on clk, off during rst
`define ESR_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("esr assertion failed");
`else
`define ESR_ASSERT_IMPL(label, a, b)
`define ESR_ASSERT_NEXT(label, a, b)
`endif
`endif

// File: design/esr_pkg.sv
// Shared types and constants for the edge stream relaxation unit.
// No dependencies; imported by esr_core and the top level.
package esr_pkg;

  localparam int VID_W          = 16;
  localparam int DIST_W         = 31;
  localparam int EPOCH_W        = 8;
  localparam int MAX_STORE_DEPTH = 65536;
  localparam int VERTEX_COUNT_DEF = 65536;
  localparam int CFG_IDX_W      = 8;

  localparam logic [DIST_W-1:0] INF_DIST = 31'd2000000000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 8'd1;

  typedef struct packed {
    logic [VID_W-1:0] source_vertex;
    logic [VID_W-1:0] target_vertex;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] target_distance;
    logic              target_reached;
  } result_t;

  typedef struct packed {
    logic clearing;     // tag sweep in progress
    logic result_wait;  // result ready, output register still full
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_TREAD,
    ST_TOUT
  } state_t;

endpackage

// File: design/esr_mem.sv
// Vertex memory: one write port, two read ports with registered read data.
// Depends on nothing but its parameters.
module esr_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 39
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_a_addr,
  output logic [DATA_W-1:0] rd_a_data,
  input  logic [ADDR_W-1:0] rd_b_addr,
  output logic [DATA_W-1:0] rd_b_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, registered read data
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// File: design/esr_core.sv
// Relaxation sequencer: reads, relaxes and writes back vertex entries.
// Depends on esr_pkg and instantiates esr_mem.
module esr_core import esr_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VID_W-1:0] from_vertex,
  input  logic [VID_W-1:0] to_vertex,
  input  logic [DIST_W-1:0] edge_weight,
  input  logic             last_edge,
  input  logic             out_free,
  output logic             res_valid,
  output result_t          res,
  output status_t          status
);

  localparam int STORE_DEPTH = (VERTEX_COUNT < MAX_STORE_DEPTH) ? VERTEX_COUNT
                                                                : MAX_STORE_DEPTH;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ENTRY_W = EPOCH_W + DIST_W;
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // control registers
  state_t             state, state_next;
  logic [ADDR_W-1:0]  clr_addr, clr_addr_next;
  logic [EPOCH_W-1:0] epoch, epoch_next;

  // item and intermediate registers
  logic [VID_W-1:0]  from_q, to_q;
  logic [DIST_W-1:0] weight_q;
  logic              last_q;
  logic [DIST_W-1:0] cand, to_dist;
  logic              upd_ok, to_hit;

  // memory ports
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr, rd_a_addr, rd_b_addr;
  logic [ENTRY_W-1:0] wr_data, rd_a_data, rd_b_data;

  esr_mem #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  // entry decode: tag equal to current epoch means reached in this pass
  logic [EPOCH_W-1:0] a_tag, b_tag;
  logic [DIST_W-1:0]  a_dist, b_dist;
  assign a_tag  = rd_a_data[ENTRY_W-1 -: EPOCH_W];
  assign a_dist = rd_a_data[DIST_W-1:0];
  assign b_tag  = rd_b_data[ENTRY_W-1 -: EPOCH_W];
  assign b_dist = rd_b_data[DIST_W-1:0];

  // fetch stage: tail lookup and candidate with a range check against INF_DIST
  logic              from_exists, to_exists, from_is_src, from_reached;
  logic [DIST_W-1:0] from_dist;
  logic [DIST_W:0]   sum;
  logic              sum_ok;
  assign from_exists  = ({16'd0, from_q} < 32'(STORE_DEPTH));
  assign to_exists    = ({16'd0, to_q} < 32'(STORE_DEPTH));
  assign from_is_src  = (from_q == cfg.source_vertex);
  assign from_reached = from_exists && (from_is_src || (a_tag == epoch));
  assign from_dist    = from_is_src ? '0 : a_dist;
  assign sum          = {1'b0, from_dist} + {1'b0, weight_q};
  assign sum_ok       = (sum < {1'b0, INF_DIST});

  // target lookup for the result
  logic tgt_exists, tgt_is_src, tgt_hit;
  assign tgt_exists = ({16'd0, cfg.target_vertex} < 32'(STORE_DEPTH));
  assign tgt_is_src = (cfg.target_vertex == cfg.source_vertex);
  assign tgt_hit    = (a_tag == epoch);

  always_comb begin
    res.target_distance = INF_DIST;
    res.target_reached  = 1'b0;
    if (tgt_exists && tgt_is_src) begin
      res.target_distance = '0;
      res.target_reached  = 1'b1;
    end else if (tgt_exists && tgt_hit) begin
      res.target_distance = a_dist;
      res.target_reached  = 1'b1;
    end
  end

  // item capture and fetch results
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      from_q   <= from_vertex;
      to_q     <= to_vertex;
      weight_q <= edge_weight;
      last_q   <= last_edge;
    end
    if (state == ST_FETCH) begin
      cand    <= sum[DIST_W-1:0];
      upd_ok  <= from_reached && to_exists && (to_q != cfg.source_vertex) && sum_ok;
      to_hit  <= (b_tag == epoch);
      to_dist <= b_dist;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      epoch    <= EPOCH_FIRST;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      epoch    <= epoch_next;
    end
  end

  // next state, memory control and handshake
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    epoch_next    = epoch;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = to_q[ADDR_W-1:0];
    wr_data       = {epoch, cand};
    rd_a_addr     = cfg.target_vertex[ADDR_W-1:0];
    rd_b_addr     = to_vertex[ADDR_W-1:0];
    status.clearing    = 1'b0;
    status.result_wait = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        status.clearing = 1'b1;
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == LAST_ADDR) begin
          clr_addr_next = '0;
          epoch_next    = EPOCH_FIRST;
          state_next    = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        rd_a_addr = from_vertex[ADDR_W-1:0];
        if (in_valid) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        wr_en      = upd_ok && (!to_hit || (cand < to_dist));
        state_next = last_q ? ST_TREAD : ST_IDLE;
      end
      ST_TREAD: begin
        state_next = ST_TOUT;
      end
      ST_TOUT: begin
        status.result_wait = !out_free;
        if (out_free) begin
          res_valid = 1'b1;
          // new pass: bump the epoch, sweep tags when it runs out
          if (epoch == '1) begin
            state_next = ST_CLEAR;
          end else begin
            epoch_next = epoch + 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: design/edge_stream_relaxation_unit.sv
// Edge stream relaxation unit: configuration registers, stream ports, output register.
// Depends on esr_pkg, esr_core and edge_stream_relaxation_unit_defines.svh.
//
// One pass of shortest-path edge relaxation over a stream of weighted edges. Each
// item is one edge; an edge goes through accept, memory read, and compare and
// write back before the next is accepted, and the edge marked by tlast then reads
// the target and waits for the output register, after which the target's distance
// and reached flag come out as one item. Every vertex entry of the single vertex
// memory carries an 8-bit pass tag, so the end of a pass clears all reached flags at
// once; after reset and after every 255th pass a tag sweep over min(VERTEX_COUNT,
// 65536) entries runs with s_tready low. Configuration writes are taken at any time,
// but should be made only while no pass item is in flight.
`include "edge_stream_relaxation_unit_defines.svh"

module edge_stream_relaxation_unit import esr_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // edge input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // from_vertex[15:0], to_vertex[31:16],
                                          // edge_weight[62:32], zero[63]
  input  logic                 s_tlast,   // last_edge
  // result output
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // target_distance[30:0], zero[31]
  output logic                 m_tuser,   // target_reached
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VID_W-1:0]     cfg_data
);

  cfg_t    cfg;
  result_t res, out_q;
  status_t status;
  logic    res_valid, out_free;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SOURCE: cfg.source_vertex <= cfg_data;
        CFG_TARGET: cfg.target_vertex <= cfg_data;
        default: ;
      endcase
    end
  end

  esr_core #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .from_vertex (s_tdata[15:0]),
    .to_vertex   (s_tdata[31:16]),
    .edge_weight (s_tdata[62:32]),
    .last_edge   (s_tlast),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .status      (status)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {1'b0, out_q.target_distance};
  assign m_tuser = out_q.target_reached;

  // checks
  `ESR_ASSERT_IMPL(a_no_accept_when_busy, status.clearing || status.result_wait, !s_tready)
  `ESR_ASSERT_NEXT(a_one_edge_at_a_time, s_tvalid && s_tready, !s_tready)
  `ESR_ASSERT_IMPL(a_no_result_overwrite, res_valid, !(m_tvalid && !m_tready))
  `ESR_ASSERT_IMPL(a_reached_dist_finite, res_valid,
                   res.target_reached == (res.target_distance != INF_DIST))

endmodule

// File: bench/edge_stream_relaxation_unit_tb.sv
// Self-checking testbench for the edge stream relaxation unit.
// Depends on esr_pkg and the edge_stream_relaxation_unit top level.
// Directed corner passes, then random passes over small vertex pools.
`timescale 1ns / 100ps

module edge_stream_relaxation_unit_tb;
  import esr_pkg::*;

  localparam int VERTEX_COUNT  = VERTEX_COUNT_DEF;
  localparam int RANDOM_EDGES  = 1150;
  localparam int MIN_PASSES    = 260;   // enough to cross a tag sweep mid-run
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 300000;

  typedef struct packed {
    logic              last;
    logic [DIST_W-1:0] weight;
    logic [VID_W-1:0]  to_v;
    logic [VID_W-1:0]  from_v;
  } edge_item_t;

  // DUT inputs, all known from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;   // from_vertex[15:0], to_vertex[31:16],
                                        // edge_weight[62:32], zero[63]
  logic                 s_tlast = 1'b0; // last_edge
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;        // target_distance[30:0], zero[31]
  logic                 m_tuser;        // target_reached
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VID_W-1:0]     cfg_data = '0;

  edge_stream_relaxation_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow state of the block
  logic [DIST_W-1:0] dist_mem [MAX_STORE_DEPTH];
  bit                reached_mem [MAX_STORE_DEPTH];
  logic [VID_W-1:0]  touched [$];
  logic [VID_W-1:0]  cur_source = '0;
  logic [VID_W-1:0]  cur_target = '0;

  edge_item_t pending_edges [$];
  result_t    target_reports [$];
  edge_item_t cur_edge;

  int  edges_queued   = 0;
  int  edges_accepted = 0;
  int  passes_done    = 0;
  int  results_seen   = 0;
  int  reg_writes     = 0;
  int  fail_count     = 0;
  int  send_gap       = 0;
  int  stall_left     = 0;
  int  quiet_cycles   = 0;
  bit  no_idle        = 1'b0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // distance of a vertex, source pinned at zero
  function automatic logic [DIST_W-1:0] vertex_distance(input logic [VID_W-1:0] v,
                                                        output logic hit);
    hit = 1'b0;
    vertex_distance = INF_DIST;
    if (int'(v) < VERTEX_COUNT) begin
      if (v == cur_source) begin
        hit = 1'b1;
        vertex_distance = '0;
      end else if (reached_mem[v]) begin
        hit = 1'b1;
        vertex_distance = dist_mem[v];
      end
    end
  endfunction

  // relax one edge; on the last edge of a pass queue the target report
  function automatic void relax_edge(input edge_item_t e);
    logic              tail_hit;
    logic              tgt_hit;
    logic [DIST_W-1:0] tail_dist;
    logic [DIST_W-1:0] cand;
    logic [DIST_W:0]   sum;
    result_t           rpt;
    tail_dist = vertex_distance(e.from_v, tail_hit);
    if (tail_hit && int'(e.to_v) < VERTEX_COUNT && e.to_v != cur_source) begin
      sum  = {1'b0, tail_dist} + {1'b0, e.weight};
      cand = (sum >= {1'b0, INF_DIST}) ? INF_DIST : sum[DIST_W-1:0];
      if (cand < INF_DIST && (!reached_mem[e.to_v] || cand < dist_mem[e.to_v])) begin
        if (!reached_mem[e.to_v]) touched.push_back(e.to_v);
        dist_mem[e.to_v]    = cand;
        reached_mem[e.to_v] = 1'b1;
      end
    end
    if (e.last) begin
      rpt.target_distance = vertex_distance(cur_target, tgt_hit);
      rpt.target_reached  = tgt_hit;
      target_reports.push_back(rpt);
      foreach (touched[i]) reached_mem[touched[i]] = 1'b0;
      touched.delete();
      passes_done++;
    end
  endfunction

  // edge driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        relax_edge(cur_edge);
        edges_accepted++;
      end
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_edges.size() != 0) begin
        cur_edge = pending_edges.pop_front();
        s_tdata  <= {1'b0, cur_edge.weight, cur_edge.to_v, cur_edge.from_v};
        s_tlast  <= cur_edge.last;
        s_tvalid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (target_reports.size() == 0) begin
          $error("unexpected result item: target_distance %0d, target_reached %0d",
                 m_tdata[DIST_W-1:0], m_tuser);
          fail_count++;
        end else begin
          result_t exp_rpt;
          exp_rpt = target_reports.pop_front();
          if (m_tdata[DIST_W-1:0] !== exp_rpt.target_distance) begin
            $error("target_distance: expected %0d, actual %0d",
                   exp_rpt.target_distance, m_tdata[DIST_W-1:0]);
            fail_count++;
          end
          if (m_tuser !== exp_rpt.target_reached) begin
            $error("target_reached: expected %0d, actual %0d",
                   exp_rpt.target_reached, m_tuser);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("edge_stream_relaxation_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_edge(input logic [VID_W-1:0] from_v, input logic [VID_W-1:0] to_v,
                           input logic [DIST_W-1:0] weight, input logic last);
    edge_item_t e;
    e.from_v = from_v;
    e.to_v   = to_v;
    e.weight = weight;
    e.last   = last;
    pending_edges.push_back(e);
    edges_queued++;
  endtask

  // all edges taken, all reports back, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk);
    while (edges_accepted != edges_queued || target_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VID_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SOURCE) cur_source = val;
    else if (idx == CFG_TARGET) cur_target = val;
    reg_writes++;
  endtask

  initial begin
    logic [VID_W-1:0]  base;
    logic [VID_W-1:0]  src;
    logic [VID_W-1:0]  tgt;
    logic [VID_W-1:0]  f;
    logic [VID_W-1:0]  t;
    logic [DIST_W-1:0] w;
    int                pool;
    int                len;
    int                rand_edges;
    int                passes_sent;
    rand_edges  = 0;
    passes_sent = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: target is the source
    push_edge(16'd0, 16'd1, 31'd5, 1'b1);
    wait_idle();

    // saturation, infinite candidate, unreached tail, head at source, ties
    write_reg(CFG_SOURCE, 16'd100);
    write_reg(CFG_TARGET, 16'd103);
    push_edge(16'd100, 16'd101, 31'h7FFF_FFFF, 1'b0);
    push_edge(16'd100, 16'd101, INF_DIST, 1'b0);
    push_edge(16'd100, 16'd101, INF_DIST - 31'd1, 1'b0);
    push_edge(16'd101, 16'd102, 31'd1, 1'b0);
    push_edge(16'd101, 16'd102, 31'd0, 1'b0);
    push_edge(16'd105, 16'd103, 31'd1, 1'b0);
    push_edge(16'd101, 16'd100, 31'd0, 1'b0);
    push_edge(16'd100, 16'd103, 31'd50, 1'b0);
    push_edge(16'd100, 16'd103, 31'd60, 1'b0);
    push_edge(16'd100, 16'd103, 31'd50, 1'b0);
    push_edge(16'd100, 16'd103, 31'd10, 1'b1);
    // reached flags are gone in the next pass
    push_edge(16'd101, 16'd103, 31'd1, 1'b1);
    wait_idle();

    // extreme vertex numbers
    write_reg(CFG_SOURCE, 16'hFFFF);
    write_reg(CFG_TARGET, 16'd0);
    push_edge(16'hFFFF, 16'hFFFF, 31'd3, 1'b0);
    push_edge(16'hFFFF, 16'd0, 31'd0, 1'b1);
    wait_idle();
    write_reg(CFG_SOURCE, 16'd0);
    write_reg(CFG_TARGET, 16'hFFFF);
    push_edge(16'd0, 16'hFFFF, INF_DIST - 31'd1, 1'b0);
    push_edge(16'hFFFF, 16'hFFFF, 31'd0, 1'b1);

    // random phases over a small pool of vertices around a base
    while (rand_edges < RANDOM_EDGES || passes_sent < MIN_PASSES) begin
      case ($urandom_range(0, 9))
        0:       base = 16'd0;
        1:       base = 16'hFFFF;
        2:       base = 16'hFFFA;
        default: base = 16'($urandom_range(0, 65535));
      endcase
      pool = $urandom_range(2, 12);
      src  = base;
      if ($urandom_range(0, 9) == 0) src = 16'($urandom);
      tgt  = base + 16'($urandom_range(0, pool - 1));
      if ($urandom_range(0, 9) == 0) tgt = 16'($urandom);

      wait_idle();
      no_idle = ($urandom_range(0, 4) == 0);
      write_reg(CFG_SOURCE, src);
      write_reg(CFG_TARGET, tgt);

      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 19))
          0:           len = $urandom_range(11, 24);
          1, 2, 3, 4:  len = $urandom_range(5, 10);
          default:     len = $urandom_range(1, 4);
        endcase
        for (int k = 0; k < len; k++) begin
          // mostly edges inside the pool, some noise over the whole range
          if ($urandom_range(0, 4) == 0) begin
            f = 16'($urandom);
            t = 16'($urandom);
          end else begin
            f = ($urandom_range(0, 2) == 0) ? src : base + 16'($urandom_range(0, pool - 1));
            t = base + 16'($urandom_range(0, pool - 1));
          end
          case ($urandom_range(0, 9))
            0:       w = 31'($urandom);
            1:       w = INF_DIST - 31'($urandom_range(0, 2000));
            2:       w = INF_DIST + 31'($urandom_range(0, 147483647));
            default: w = 31'($urandom_range(0, 1000));
          endcase
          push_edge(f, t, w, k == len - 1);
          rand_edges++;
        end
        passes_sent++;
      end
    end

    wait_idle();
    $display("covered %0d edges in %0d passes, %0d target reports checked",
             edges_accepted, passes_done, results_seen);
    $display("%0d register writes, vertices 0 and 65535 among sources and targets",
             reg_writes);
    if (fail_count == 0) begin
      $display("edge_stream_relaxation_unit: match");
    end else begin
      $display("edge_stream_relaxation_unit: mismatch");
    end
    $finish;
  end

endmodule
